/* src/aes_pkg.sv */
// Package: AES-128 constants, S-box and round helper functions.
`default_nettype none
package aes_pkg;
  localparam int BlockBits = 128;
  localparam int FullRounds = 9;
  localparam int NumRounds = FullRounds + 1;
  localparam int KeyIndexBits = 1;
  localparam logic [KeyIndexBits-1:0] RegKeyUpper = 1'b0;
  localparam logic [KeyIndexBits-1:0] RegKeyLower = 1'b1;

  typedef logic [BlockBits-1:0] block_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] tab [256];
    tab = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return tab[a];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of the block sits at bits [127-8i -: 8].
  function automatic logic [7:0] byte_at(input block_t s, input int i);
    return s[BlockBits-1-8*i -: 8];
  endfunction

  function automatic block_t next_key(input block_t k, input logic [3:0] r);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockBits-1-8*(4*c+r) -: 8] = sbox(byte_at(s, 4*((c+r)%4)+r));
      end
    end
    return t;
  endfunction

  function automatic block_t mix(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_at(s, 4*c);
      a1 = byte_at(s, 4*c+1);
      a2 = byte_at(s, 4*c+2);
      a3 = byte_at(s, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[BlockBits-1-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                                   a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
    end
    return t;
  endfunction
endpackage
`default_nettype wire

/* src/aes_if.sv */
// Interfaces: block stream channel and configuration write channel.
`default_nettype none
interface aes_blk_if;
  logic valid;
  logic ready;
  logic [63:0] upper;
  logic [63:0] lower;
  modport source(output valid, output upper, output lower, input ready);
  modport sink(input valid, input upper, input lower, output ready);
endinterface

interface aes_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [63:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* src/aes128_block_encrypt.sv */
// Top level: fully pipelined AES-128 encryption, one round per stage.
`default_nettype none
// Pipelined AES-128 ECB encryptor. One 128-bit block transfer is taken each
// cycle while the pipe advances; a block's ciphertext leaves from stage 10
// (stage 0 adds the cipher key, stages 1 to 10 run one round each, with the
// round key expanded alongside the data so each stage but the last carries
// its own key). The whole pipe advances together when the output stage is
// empty or being taken, so a stall holds every stage and loses nothing. The
// key registers sample the configuration channel, which is always ready; a
// new key takes effect for blocks that enter after the write.
module aes128_block_encrypt
  import aes_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  aes_cfg_if.sink cfg,
  aes_blk_if.sink plain,
  aes_blk_if.source cipher
);
  logic [63:0] key_upper, key_lower;
  logic [NumRounds:0] vld;
  block_t st [NumRounds+1];
  block_t rk [NumRounds];
  logic advance;

  // Advance the pipe unless the output holds an untaken result.
  assign advance = !vld[NumRounds] || cipher.ready;
  assign plain.ready = advance;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= '0;
      key_lower <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        RegKeyUpper: key_upper <= cfg.data;
        RegKeyLower: key_lower <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NumRounds-1:0], plain.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st[0] <= {plain.upper, plain.lower} ^ {key_upper, key_lower};
      rk[0] <= {key_upper, key_lower};
      for (int r = 1; r <= NumRounds; r++) begin
        if (r == NumRounds) begin
          st[r] <= sub_shift(st[r-1]) ^ next_key(rk[r-1], 4'(r));
        end else begin
          rk[r] <= next_key(rk[r-1], 4'(r));
          st[r] <= mix(sub_shift(st[r-1])) ^ next_key(rk[r-1], 4'(r));
        end
      end
    end
  end

  assign cipher.valid = vld[NumRounds];
  assign cipher.upper = st[NumRounds][127:64];
  assign cipher.lower = st[NumRounds][63:0];

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    cipher.valid && !cipher.ready |=> cipher.valid && $stable(cipher.upper))
    else $error("stalled result changed");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !cipher.valid |-> plain.ready) else $error("empty output blocks input");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    plain.valid && plain.ready |=> vld[0]) else $error("accepted block lost");
`endif
endmodule
`default_nettype wire
